>>> rtl/ctae_pkg.sv
package ctae_pkg;

    localparam int CLASS_W     = 6;
    localparam int NUM_CLASSES = 1 << CLASS_W;
    localparam int CNT_W       = $clog2(NUM_CLASSES + 2);
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;

    typedef logic [CLASS_W-1:0]  class_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [CMD_W-1:0]    command_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam command_t CMD_ADD_EDGE = 3'd0;
    localparam command_t CMD_CONFORM  = 3'd1;
    localparam command_t CMD_LCA      = 3'd2;
    localparam command_t CMD_ACYCLIC  = 3'd3;
    localparam command_t CMD_LEAF     = 3'd4;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_IGNORED = 2'd1;
    localparam status_t ST_BROKEN  = 2'd2;

    typedef struct packed {
        command_t command;
        class_t   class_a;
        class_t   class_b;
    } in_word_t;

    typedef struct packed {
        logic    answer_flag;
        class_t  ancestor_class;
        status_t status;
    } out_word_t;

    typedef enum logic [2:0] {
        RD_X,
        RD_A,
        RD_B,
        RD_C,
        RD_RDATA
    } rd_sel_t;

    typedef struct packed {
        logic    load_in;
        logic    x_load_b;
        logic    x_load_rd;
        logic    n_clear;
        logic    n_inc;
        logic    da_load_n;
        logic    db_load_n;
        logic    da_dec;
        logic    db_dec;
        logic    a_load_rd;
        logic    b_load_rd;
        rd_sel_t rd_sel;
        logic    wr_en;
        logic    c_inc;
        logic    vis_init;
        logic    vis_mark;
        logic    res_we;
        logic    res_flag;
        status_t res_status;
        logic    res_anc_a;
        logic    out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic ab_eq;
        logic pv_a;
        logic x_is_root;
        logic x_eq_b;
        logic pv_x;
        logic n_over;
        logic da_gt_db;
        logic db_gt_da;
        logic da_zero;
        logic pv_c;
        logic c_is_root;
        logic c_last;
        logic rd_visited;
        logic rd_is_root;
        logic pv_rd;
        logic rd_eq_a;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/ctae_ram.sv
module ctae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ctae_dp.sv
module ctae_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctae_pkg::in_word_t  s_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  ctae_pkg::class_t    cfg_data,
    input  ctae_pkg::ctl_cmd_t  cmd,
    output ctae_pkg::dp_stat_t  stat,
    output logic                m_valid,
    input  logic                m_ready,
    output ctae_pkg::out_word_t m_word
);
    import ctae_pkg::*;

    class_t                 root_reg;
    class_t                 a_reg;
    class_t                 b_reg;
    class_t                 x_reg;
    class_t                 c_reg;
    cnt_t                   n_reg;
    cnt_t                   da_reg;
    cnt_t                   db_reg;
    logic [NUM_CLASSES-1:0] pv_reg;
    logic [NUM_CLASSES-1:0] vis_reg;
    out_word_t              res_reg;
    out_word_t              m_word_reg;
    logic                   m_valid_reg;
    class_t                 raddr;
    class_t                 rdata;

    assign cfg_ready = 1'b1;

    always_comb begin
        case (cmd.rd_sel)
            RD_X:     raddr = x_reg;
            RD_A:     raddr = a_reg;
            RD_B:     raddr = b_reg;
            RD_C:     raddr = c_reg;
            RD_RDATA: raddr = rdata;
            default:  raddr = x_reg;
        endcase
    end

    ctae_ram #(
        .WIDTH(CLASS_W),
        .DEPTH(NUM_CLASSES)
    ) u_parent_ram (
        .aclk (aclk),
        .we   (cmd.wr_en),
        .waddr(a_reg),
        .wdata(b_reg),
        .raddr(raddr),
        .rdata(rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg    <= '0;
            pv_reg      <= '0;
            vis_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                root_reg <= cfg_data;
            end
            if (cmd.wr_en) begin
                pv_reg[a_reg] <= 1'b1;
            end
            if (cmd.vis_init) begin
                vis_reg <= {{(NUM_CLASSES-1){1'b0}}, 1'b1} << c_reg;
            end else if (cmd.vis_mark) begin
                vis_reg[rdata] <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // walk registers and result
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            a_reg <= s_word.class_a;
            b_reg <= s_word.class_b;
        end else begin
            if (cmd.a_load_rd) begin
                a_reg <= rdata;
            end
            if (cmd.b_load_rd) begin
                b_reg <= rdata;
            end
        end

        if (cmd.load_in) begin
            x_reg <= s_word.class_a;
        end else if (cmd.x_load_b) begin
            x_reg <= b_reg;
        end else if (cmd.x_load_rd) begin
            x_reg <= rdata;
        end

        if (cmd.load_in || cmd.n_clear) begin
            n_reg <= '0;
        end else if (cmd.n_inc) begin
            n_reg <= n_reg + CNT_W'(1);
        end

        if (cmd.da_load_n) begin
            da_reg <= n_reg;
        end else if (cmd.da_dec) begin
            da_reg <= da_reg - CNT_W'(1);
        end

        if (cmd.db_load_n) begin
            db_reg <= n_reg;
        end else if (cmd.db_dec) begin
            db_reg <= db_reg - CNT_W'(1);
        end

        if (cmd.load_in) begin
            c_reg <= '0;
        end else if (cmd.c_inc) begin
            c_reg <= c_reg + CLASS_W'(1);
        end

        if (cmd.load_in) begin
            res_reg <= '0;
        end else if (cmd.res_we) begin
            res_reg.answer_flag    <= cmd.res_flag;
            res_reg.ancestor_class <= cmd.res_anc_a ? a_reg : '0;
            res_reg.status         <= cmd.res_status;
        end

        if (cmd.out_load) begin
            m_word_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    always_comb begin
        stat.ab_eq      = (a_reg == b_reg);
        stat.pv_a       = pv_reg[a_reg];
        stat.x_is_root  = (x_reg == root_reg);
        stat.x_eq_b     = (x_reg == b_reg);
        stat.pv_x       = pv_reg[x_reg];
        stat.n_over     = (n_reg > CNT_W'(NUM_CLASSES));
        stat.da_gt_db   = (da_reg > db_reg);
        stat.db_gt_da   = (db_reg > da_reg);
        stat.da_zero    = (da_reg == '0);
        stat.pv_c       = pv_reg[c_reg];
        stat.c_is_root  = (c_reg == root_reg);
        stat.c_last     = (c_reg == CLASS_W'(NUM_CLASSES - 1));
        stat.rd_visited = vis_reg[rdata];
        stat.rd_is_root = (rdata == root_reg);
        stat.pv_rd      = pv_reg[rdata];
        stat.rd_eq_a    = (rdata == a_reg);
        stat.out_free   = !m_valid_reg || m_ready;
    end

endmodule

>>> rtl/ctae_ctrl.sv
module ctae_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ctae_pkg::command_t  command,
    input  ctae_pkg::dp_stat_t  stat,
    output ctae_pkg::ctl_cmd_t  cmd
);
    import ctae_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE    = 20'd1,
        S_ADD     = 20'd2,
        S_CF_WALK = 20'd4,
        S_CF_WAIT = 20'd8,
        S_LCA0    = 20'd16,
        S_DA_WALK = 20'd32,
        S_DA_WAIT = 20'd64,
        S_DB_WALK = 20'd128,
        S_DB_WAIT = 20'd256,
        S_EQ      = 20'd512,
        S_UPA_W   = 20'd1024,
        S_UPB_W   = 20'd2048,
        S_MEET    = 20'd4096,
        S_MA_W    = 20'd8192,
        S_MB_W    = 20'd16384,
        S_AC_SCAN = 20'd32768,
        S_AC_STEP = 20'd65536,
        S_LF_RD   = 20'd131072,
        S_LF_CMP  = 20'd262144,
        S_FIN     = 20'd524288
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_X;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    case (command)
                        CMD_ADD_EDGE: state_next = S_ADD;
                        CMD_CONFORM:  state_next = S_CF_WALK;
                        CMD_LCA:      state_next = S_LCA0;
                        CMD_ACYCLIC:  state_next = S_AC_SCAN;
                        CMD_LEAF:     state_next = S_LF_RD;
                        default:      state_next = S_FIN;
                    endcase
                end
            end
            S_ADD: begin
                if (stat.pv_a) begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ST_IGNORED;
                end else begin
                    cmd.wr_en = 1'b1;
                end
                state_next = S_FIN;
            end
            S_CF_WALK: begin
                if (stat.n_over) begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ST_BROKEN;
                    state_next     = S_FIN;
                end else if (stat.x_is_root || stat.x_eq_b) begin
                    cmd.res_we   = 1'b1;
                    cmd.res_flag = stat.x_eq_b;
                    state_next   = S_FIN;
                end else if (!stat.pv_x) begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ST_BROKEN;
                    state_next     = S_FIN;
                end else begin
                    state_next = S_CF_WAIT;
                end
            end
            S_CF_WAIT: begin
                cmd.x_load_rd = 1'b1;
                cmd.n_inc     = 1'b1;
                state_next    = S_CF_WALK;
            end
            S_LCA0: begin
                if (stat.ab_eq) begin
                    cmd.res_we    = 1'b1;
                    cmd.res_anc_a = 1'b1;
                    state_next    = S_FIN;
                end else begin
                    state_next = S_DA_WALK;
                end
            end
            S_DA_WALK, S_DB_WALK: begin
                if (stat.n_over) begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ST_BROKEN;
                    state_next     = S_FIN;
                end else if (stat.x_is_root) begin
                    if (state_reg == S_DA_WALK) begin
                        cmd.da_load_n = 1'b1;
                        cmd.x_load_b  = 1'b1;
                        cmd.n_clear   = 1'b1;
                        state_next    = S_DB_WALK;
                    end else begin
                        cmd.db_load_n = 1'b1;
                        state_next    = S_EQ;
                    end
                end else if (!stat.pv_x) begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ST_BROKEN;
                    state_next     = S_FIN;
                end else begin
                    state_next = (state_reg == S_DA_WALK) ? S_DA_WAIT : S_DB_WAIT;
                end
            end
            S_DA_WAIT: begin
                cmd.x_load_rd = 1'b1;
                cmd.n_inc     = 1'b1;
                state_next    = S_DA_WALK;
            end
            S_DB_WAIT: begin
                cmd.x_load_rd = 1'b1;
                cmd.n_inc     = 1'b1;
                state_next    = S_DB_WALK;
            end
            S_EQ: begin
                if (stat.da_gt_db) begin
                    cmd.rd_sel = RD_A;
                    state_next = S_UPA_W;
                end else if (stat.db_gt_da) begin
                    cmd.rd_sel = RD_B;
                    state_next = S_UPB_W;
                end else begin
                    state_next = S_MEET;
                end
            end
            S_UPA_W: begin
                cmd.a_load_rd = 1'b1;
                cmd.da_dec    = 1'b1;
                state_next    = S_EQ;
            end
            S_UPB_W: begin
                cmd.b_load_rd = 1'b1;
                cmd.db_dec    = 1'b1;
                state_next    = S_EQ;
            end
            S_MEET: begin
                if (!stat.ab_eq && !stat.da_zero) begin
                    cmd.rd_sel = RD_A;
                    state_next = S_MA_W;
                end else begin
                    cmd.res_we    = 1'b1;
                    cmd.res_anc_a = 1'b1;
                    state_next    = S_FIN;
                end
            end
            S_MA_W: begin
                cmd.a_load_rd = 1'b1;
                cmd.rd_sel    = RD_B;
                state_next    = S_MB_W;
            end
            S_MB_W: begin
                cmd.b_load_rd = 1'b1;
                cmd.da_dec    = 1'b1;
                state_next    = S_MEET;
            end
            S_AC_SCAN: begin
                if (stat.pv_c && !stat.c_is_root) begin
                    cmd.rd_sel   = RD_C;
                    cmd.vis_init = 1'b1;
                    state_next   = S_AC_STEP;
                end else if (stat.c_last) begin
                    cmd.res_we   = 1'b1;
                    cmd.res_flag = 1'b1;
                    state_next   = S_FIN;
                end else begin
                    cmd.c_inc = 1'b1;
                end
            end
            S_AC_STEP: begin
                if (stat.rd_visited) begin
                    state_next = S_FIN;
                end else if (stat.rd_is_root) begin
                    if (stat.c_last) begin
                        cmd.res_we   = 1'b1;
                        cmd.res_flag = 1'b1;
                        state_next   = S_FIN;
                    end else begin
                        cmd.c_inc  = 1'b1;
                        state_next = S_AC_SCAN;
                    end
                end else if (!stat.pv_rd) begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = ST_BROKEN;
                    state_next     = S_FIN;
                end else begin
                    cmd.vis_mark = 1'b1;
                    cmd.rd_sel   = RD_RDATA;
                end
            end
            S_LF_RD: begin
                cmd.rd_sel = RD_C;
                state_next = S_LF_CMP;
            end
            S_LF_CMP: begin
                if (stat.pv_c && stat.rd_eq_a) begin
                    state_next = S_FIN;
                end else if (stat.c_last) begin
                    cmd.res_we   = 1'b1;
                    cmd.res_flag = 1'b1;
                    state_next   = S_FIN;
                end else begin
                    cmd.c_inc  = 1'b1;
                    state_next = S_LF_RD;
                end
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/class_tree_ancestor_engine_top.sv
// Parent-pointer class tree engine: one command word in, one result word out, one
// command at a time. Parents live in a single-port-read RAM, so a step up a chain
// is split into a walk state that presents the address and a wait state that loads
// the registered read data, except in check acyclic where the read data addresses
// the next read. Check acyclic scans all 64 classes and walks each chain. A finished
// result sits in an output register, so the next command is taken while it waits.
// root_class is written through cfg_* at any idle time.
module class_tree_ancestor_engine_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ctae_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output ctae_pkg::out_word_t m_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  ctae_pkg::class_t    cfg_data
);
    import ctae_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    ctae_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .command(s_word.command),
        .stat   (stat),
        .cmd    (cmd)
    );

    ctae_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_word   (s_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (m_word)
    );

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ctae_pkg::*;

    localparam command_t CMD_RSVD_LO  = 3'd5;
    localparam command_t CMD_RSVD_MID = 3'd6;
    localparam command_t CMD_RSVD_HI  = 3'd7;
    localparam int       HOLD_CYCLES  = 400;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_word_t  s_word    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_word_t m_word;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    class_t    cfg_data  = '0;

    class_tree_ancestor_engine_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // tree state as the block should hold it
    class_t up_link [NUM_CLASSES];
    logic   has_up  [NUM_CLASSES];
    class_t root_cls;

    // stimulus bookkeeping
    logic [NUM_CLASSES-1:0] planned_link;
    logic [NUM_CLASSES-1:0] reaches_root;

    in_word_t  pending_words [$];
    out_word_t expected_results [$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        mismatch_count = 0;
    int        hold_left = 0;
    logic      hold_kick = 1'b0;

    function automatic bit chain_depth(input class_t start, output int depth);
        class_t cur;
        int     steps;
        cur   = start;
        steps = 0;
        depth = 0;
        while (cur != root_cls) begin
            if (!has_up[cur]) return 1'b0;
            cur = up_link[cur];
            steps++;
            if (steps > NUM_CLASSES) return 1'b0;
        end
        depth = steps;
        return 1'b1;
    endfunction

    function automatic void climb_conform(input class_t a, input class_t b,
                                          output logic hit, output status_t st);
        class_t cur;
        int     steps;
        cur   = a;
        steps = 0;
        hit   = 1'b0;
        st    = ST_OK;
        if (a == b) begin
            hit = 1'b1;
            return;
        end
        while (cur != root_cls) begin
            if (cur == b) begin
                hit = 1'b1;
                return;
            end
            if (!has_up[cur]) begin
                st = ST_BROKEN;
                return;
            end
            cur = up_link[cur];
            steps++;
            if (steps > NUM_CLASSES) begin
                st = ST_BROKEN;
                return;
            end
        end
        hit = (cur == b);
    endfunction

    function automatic void meet_point(input class_t a, input class_t b,
                                       output class_t anc, output status_t st);
        int     da;
        int     db;
        class_t x;
        class_t y;
        anc = '0;
        st  = ST_OK;
        x   = a;
        y   = b;
        if (a == b) begin
            anc = a;
            return;
        end
        if (!chain_depth(a, da) || !chain_depth(b, db)) begin
            st = ST_BROKEN;
            return;
        end
        while (da > db) begin
            x = up_link[x];
            da--;
        end
        while (db > da) begin
            y = up_link[y];
            db--;
        end
        while (x != y && da > 0) begin
            x = up_link[x];
            y = up_link[y];
            da--;
        end
        anc = x;
    endfunction

    function automatic void scan_for_loops(output logic acyclic, output status_t st);
        logic [NUM_CLASSES-1:0] seen;
        class_t cur;
        class_t nxt;
        acyclic = 1'b0;
        st      = ST_OK;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (has_up[c]) begin
                seen    = '0;
                seen[c] = 1'b1;
                cur     = class_t'(c);
                nxt     = up_link[c];
                while (cur != root_cls) begin
                    if (seen[nxt]) return;
                    seen[nxt] = 1'b1;
                    cur = nxt;
                    if (cur != root_cls) begin
                        if (!has_up[cur]) begin
                            st = ST_BROKEN;
                            return;
                        end
                        nxt = up_link[cur];
                    end
                end
            end
        end
        acyclic = 1'b1;
    endfunction

    function automatic out_word_t predict_result(input in_word_t w);
        out_word_t r;
        r = '0;
        case (w.command)
            CMD_ADD_EDGE: begin
                if (has_up[w.class_a]) begin
                    r.status = ST_IGNORED;
                end else begin
                    up_link[w.class_a] = w.class_b;
                    has_up[w.class_a]  = 1'b1;
                end
            end
            CMD_CONFORM: climb_conform(w.class_a, w.class_b, r.answer_flag, r.status);
            CMD_LCA:     meet_point(w.class_a, w.class_b, r.ancestor_class, r.status);
            CMD_ACYCLIC: scan_for_loops(r.answer_flag, r.status);
            CMD_LEAF: begin
                r.answer_flag = 1'b1;
                for (int c = 0; c < NUM_CLASSES; c++) begin
                    if (has_up[c] && up_link[c] == w.class_a) r.answer_flag = 1'b0;
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // command driver
    always @(posedge aclk) begin : tx_side
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results = {expected_results, predict_result(s_word)};
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_word  <= pending_words.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_kick && hold_left == 0) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge aclk) begin : rx_side
        out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with none pending", int'(m_word), -1);
                end else begin
                    want = expected_results.pop_front();
                    if (m_word.answer_flag !== want.answer_flag)
                        report_mismatch("answer_flag", m_word.answer_flag, want.answer_flag);
                    if (m_word.ancestor_class !== want.ancestor_class)
                        report_mismatch("ancestor_class", m_word.ancestor_class,
                                        want.ancestor_class);
                    if (m_word.status !== want.status)
                        report_mismatch("status", m_word.status, want.status);
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_word(input command_t cmd, input class_t a, input class_t b);
        in_word_t w;
        w.command = cmd;
        w.class_a = a;
        w.class_b = b;
        pending_words = {pending_words, w};
        if (cmd == CMD_ADD_EDGE && !planned_link[a]) begin
            planned_link[a] = 1'b1;
            if (reaches_root[b]) reaches_root[a] = 1'b1;
        end
    endtask

    function automatic class_t pick_from(input logic [NUM_CLASSES-1:0] pool);
        int start;
        start = $urandom_range(NUM_CLASSES - 1);
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (pool[(start + i) % NUM_CLASSES]) return class_t'((start + i) % NUM_CLASSES);
        end
        return class_t'(start);
    endfunction

    function automatic class_t some_class();
        if ($urandom_range(4) == 0) return class_t'($urandom_range(NUM_CLASSES - 1));
        return pick_from(reaches_root);
    endfunction

    task automatic queue_random(input int count);
        int pick;
        logic [NUM_CLASSES-1:0] free_child;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            free_child = ~planned_link;
            free_child[root_cls] = 1'b0;
            if (pick < 10) begin
                queue_word(command_t'($urandom_range(7)),
                           class_t'($urandom_range(NUM_CLASSES - 1)),
                           class_t'($urandom_range(NUM_CLASSES - 1)));
            end else if (pick < 35) begin
                queue_word(CMD_ADD_EDGE, pick_from(free_child), pick_from(reaches_root));
            end else if (pick < 40) begin
                queue_word(CMD_ACYCLIC, class_t'($urandom_range(NUM_CLASSES - 1)),
                           class_t'($urandom_range(NUM_CLASSES - 1)));
            end else if (pick < 60) begin
                queue_word(CMD_CONFORM, some_class(), some_class());
            end else if (pick < 85) begin
                queue_word(CMD_LCA, some_class(), some_class());
            end else begin
                queue_word(CMD_LEAF, some_class(), class_t'($urandom_range(NUM_CLASSES - 1)));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_root(input class_t value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        root_cls = value;
    endtask

    task automatic run_phase(input class_t root, input int tx_pct, input int rx_pct,
                             input int count, input bit long_hold);
        wait_drained();
        repeat (10) @(posedge aclk);
        write_root(root);
        reaches_root = '0;
        reaches_root[root] = 1'b1;
        send_idle_pct = tx_pct;
        recv_idle_pct = rx_pct;
        queue_random(count);
        if (long_hold) begin
            hold_kick <= 1'b1;
            @(posedge aclk);
            hold_kick <= 1'b0;
        end
    endtask

    initial begin
        root_cls = '0;
        for (int c = 0; c < NUM_CLASSES; c++) has_up[c] = 1'b0;
        planned_link = '0;
        reaches_root = '0;
        reaches_root[0] = 1'b1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 12;
        recv_idle_pct = 49;

        // empty tree, equal classes, missing parents, unused codes
        queue_word(CMD_LEAF,     6'd0,  6'd0);
        queue_word(CMD_ACYCLIC,  6'd0,  6'd0);
        queue_word(CMD_CONFORM,  6'd5,  6'd5);
        queue_word(CMD_CONFORM,  6'd5,  6'd0);
        queue_word(CMD_LCA,      6'd7,  6'd7);
        queue_word(CMD_LCA,      6'd1,  6'd2);
        queue_word(CMD_RSVD_LO,  6'd63, 6'd63);
        queue_word(CMD_RSVD_MID, 6'd0,  6'd63);
        queue_word(CMD_RSVD_HI,  6'd63, 6'd0);
        // small proper tree, repeated edge
        queue_word(CMD_ADD_EDGE, 6'd1,  6'd0);
        queue_word(CMD_ADD_EDGE, 6'd1,  6'd0);
        queue_word(CMD_ADD_EDGE, 6'd2,  6'd1);
        queue_word(CMD_ADD_EDGE, 6'd3,  6'd1);
        queue_word(CMD_ADD_EDGE, 6'd63, 6'd2);
        queue_word(CMD_CONFORM,  6'd63, 6'd1);
        queue_word(CMD_CONFORM,  6'd63, 6'd3);
        queue_word(CMD_LCA,      6'd63, 6'd3);
        queue_word(CMD_LEAF,     6'd1,  6'd0);
        // root given a parent, walks stop there
        queue_word(CMD_ADD_EDGE, 6'd0,  6'd63);
        queue_word(CMD_CONFORM,  6'd1,  6'd63);
        queue_word(CMD_ACYCLIC,  6'd0,  6'd0);
        // dangling chain with early match, then a loop below it
        queue_word(CMD_ADD_EDGE, 6'd10, 6'd11);
        queue_word(CMD_CONFORM,  6'd10, 6'd11);
        queue_word(CMD_ADD_EDGE, 6'd4,  6'd5);
        queue_word(CMD_ADD_EDGE, 6'd5,  6'd4);
        queue_word(CMD_LCA,      6'd4,  6'd1);
        queue_word(CMD_ACYCLIC,  6'd0,  6'd0);

        run_phase(6'd63, 12, 49, 150, 1'b1);
        run_phase(class_t'($urandom_range(NUM_CLASSES - 1)), 49, 12, 150, 1'b0);
        run_phase(6'd0, 49, 12, 150, 1'b0);
        run_phase(class_t'($urandom_range(NUM_CLASSES - 1)), 0, 0, 150, 1'b0);

        wait_drained();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
